/* rtl/depth_z24_z16_codec_assert.svh */
`ifndef DEPTH_Z24_Z16_CODEC_ASSERT_SVH
`define DEPTH_Z24_Z16_CODEC_ASSERT_SVH

// same-cycle implication
`define DZC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DZC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/dzc_pkg.sv */
package dzc_pkg;

   localparam int unsigned DEPTH_W = 24;
   localparam int unsigned CODE_W  = 16;
   localparam int unsigned EXP_W   = 4;
   localparam int unsigned SHIFT_W = 4;

   localparam logic [1:0] FMT_LINEAR = 2'd0;
   localparam logic [1:0] FMT_NEAR   = 2'd1;
   localparam logic [1:0] FMT_MID    = 2'd2;
   localparam logic [1:0] FMT_FAR    = 2'd3;

   localparam logic CMD_COMPRESS   = 1'b0;
   localparam logic CMD_DECOMPRESS = 1'b1;

   localparam logic [EXP_W-1:0] MAX_EXP_NEAR = 4'd3;
   localparam logic [EXP_W-1:0] MAX_EXP_MID  = 4'd7;
   localparam logic [EXP_W-1:0] MAX_EXP_FAR  = 4'd12;

   localparam logic [DEPTH_W-1:0] MASK24 = 24'hFFFFFF;

   typedef struct packed {
      logic [DEPTH_W-1:0] value;
      logic               bad;
   } dzc_result_type;

   // mantissa shift by format and exponent
   function automatic logic [SHIFT_W-1:0] shift_for(input logic [1:0] fmt,
                                                    input logic [EXP_W-1:0] e);
      logic [SHIFT_W-1:0] sh;
      sh = '0;
      unique case (fmt)
         FMT_NEAR: sh = (e == MAX_EXP_NEAR) ? 4'd7 : 4'd9 - e;
         FMT_MID:  sh = (e == MAX_EXP_MID) ? 4'd4 : 4'd10 - e;
         FMT_FAR:  sh = (e == MAX_EXP_FAR) ? 4'd0 : 4'd11 - e;
         default:  sh = '0;
      endcase
      return sh;
   endfunction

endpackage

/* rtl/depth_z24_z16_codec.sv */
// an accepted request passes through the input register and then the result register before its result is valid
// throughput: one request per cycle, sustained while the result side does not stall
// a stalled result register holds its request; the input register keeps accepting when empty
// reset: synchronous, active high, clears both valid flags; payload registers are not reset
module depth_z24_z16_codec (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [1:0]  req_depth_format,
   input  logic [23:0] req_depth_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_converted_value,
   output logic        rsp_bad_exponent
);
   import dzc_pkg::*;

`include "depth_z24_z16_codec_assert.svh"

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_cmd_ff;
   logic [1:0]         s1_fmt_ff;
   logic [DEPTH_W-1:0] s1_value_ff;

   logic               s2_valid_ff, s2_valid_in;
   logic               s2_cmd_ff;
   logic [DEPTH_W-1:0] s2_value_ff;
   logic               s2_bad_ff;

   logic           adv1, adv2;
   dzc_result_type comp_res, exp_res, sel_res;

   assign adv2      = !s2_valid_ff || !rsp_stall;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_stall = !adv1;

   assign s1_valid_in = adv1 ? req_valid : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;

   dzc_compress u_compress (
      .depth  (s1_value_ff),
      .fmt    (s1_fmt_ff),
      .result (comp_res)
   );

   dzc_expand u_expand (
      .code   (s1_value_ff[CODE_W-1:0]),
      .fmt    (s1_fmt_ff),
      .result (exp_res)
   );

   assign sel_res = (s1_cmd_ff == CMD_DECOMPRESS) ? exp_res : comp_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_cmd_ff   <= req_command;
         s1_fmt_ff   <= req_depth_format;
         s1_value_ff <= req_depth_value;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_cmd_ff   <= s1_cmd_ff;
         s2_value_ff <= sel_res.value;
         s2_bad_ff   <= sel_res.bad;
      end
   end

   assign rsp_valid           = s2_valid_ff;
   assign rsp_converted_value = s2_value_ff;
   assign rsp_bad_exponent    = s2_bad_ff;

   `DZC_ASSERT_NOW(a_bad_only_decompress, clock, reset, s2_valid_ff && s2_bad_ff, s2_cmd_ff == CMD_DECOMPRESS && s2_value_ff[23:12] == 12'hFFF, "bad exponent on wrong request")
   `DZC_ASSERT_NOW(a_compress_upper_zero, clock, reset, s2_valid_ff && s2_cmd_ff == CMD_COMPRESS, s2_value_ff[23:16] == 8'h00, "compressed code exceeds 16 bits")
   `DZC_ASSERT_NEXT(a_accept_fills_input, clock, reset, req_valid && !req_stall, s1_valid_ff, "accepted request lost")
   `DZC_ASSERT_NEXT(a_input_held_on_stall, clock, reset, s1_valid_ff && !adv2, s1_valid_ff && $stable(s1_value_ff), "input register dropped while stalled")

endmodule

/* rtl/dzc_compress.sv */
module dzc_compress (
   input  logic [23:0]             depth,
   input  logic [1:0]              fmt,
   output dzc_pkg::dzc_result_type result
);
   import dzc_pkg::*;

   logic [EXP_W-1:0]   lead;
   logic               run;
   logic [EXP_W-1:0]   exp_c;
   logic [SHIFT_W-1:0] sh;
   logic [DEPTH_W-1:0] shifted;

   // leading ones, saturating at twelve
   always_comb begin
      lead = '0;
      run  = 1'b1;
      for (int i = 0; i < 12; i++) begin
         if (run && depth[DEPTH_W-1-i]) begin
            lead = EXP_W'(i + 1);
         end else begin
            run = 1'b0;
         end
      end
   end

   always_comb begin
      unique case (fmt)
         FMT_NEAR: exp_c = (lead > MAX_EXP_NEAR) ? MAX_EXP_NEAR : lead;
         FMT_MID:  exp_c = (lead > MAX_EXP_MID) ? MAX_EXP_MID : lead;
         FMT_FAR:  exp_c = (lead > MAX_EXP_FAR) ? MAX_EXP_FAR : lead;
         default:  exp_c = '0;
      endcase
   end

   assign sh      = shift_for(fmt, exp_c);
   assign shifted = depth >> sh;

   always_comb begin
      result.bad = 1'b0;
      unique case (fmt)
         FMT_NEAR: result.value = {8'h00, exp_c[1:0], shifted[13:0]};
         FMT_MID:  result.value = {8'h00, exp_c[2:0], shifted[12:0]};
         FMT_FAR:  result.value = {8'h00, exp_c, shifted[11:0]};
         default:  result.value = {8'h00, depth[23:8]};
      endcase
   end

endmodule

/* rtl/dzc_expand.sv */
module dzc_expand (
   input  logic [15:0]             code,
   input  logic [1:0]              fmt,
   output dzc_pkg::dzc_result_type result
);
   import dzc_pkg::*;

   logic [EXP_W-1:0]   exp_c;
   logic [DEPTH_W-1:0] mant;
   logic               bad;
   logic [SHIFT_W-1:0] sh;

   always_comb begin
      bad = 1'b0;
      unique case (fmt)
         FMT_NEAR: begin
            exp_c = {2'b00, code[15:14]};
            mant  = {10'd0, code[13:0]};
         end
         FMT_MID: begin
            exp_c = {1'b0, code[15:13]};
            mant  = {11'd0, code[12:0]};
         end
         FMT_FAR: begin
            bad   = code[15:12] > MAX_EXP_FAR;
            exp_c = bad ? MAX_EXP_FAR : code[15:12];
            mant  = {12'd0, code[11:0]};
         end
         default: begin
            exp_c = '0;
            mant  = '0;
         end
      endcase
   end

   assign sh = shift_for(fmt, exp_c);

   always_comb begin
      result.bad = bad;
      if (fmt == FMT_LINEAR) begin
         result.value = {code, 8'h00};
      end else begin
         result.value = ~(MASK24 >> exp_c) | (mant << sh);
      end
   end

endmodule
